>>> hw/rtl/irl_pkg.sv
// shared types, constants and sensor curve tables for the ir range averager
package irl_pkg;

  // default configuration
  localparam int DEF_WINDOW      = 20;
  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_SAMPLE_BITS = 10;

  // fixed port field widths
  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int DIST_W     = 14;
  localparam int MASK_W     = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'd8;

  // pipeline depth from accept to result register
  localparam int STAGES = 9;

  // voltage in 1e-5 V is avg * VOLT_SCALE
  localparam int VOLT_SCALE    = 489;
  localparam int SHORT_FLOOR_P = 31000;

  // segment fields: breakpoint in 1e-5 V, offset in 1e-8 inch, slope in 1e-3 inch per volt
  localparam int THR_W = 19;
  localparam int A_W   = 34;
  localparam int B_W   = 17;
  localparam int D_W   = 33;

  // 60 inch in 1e-8 inch
  localparam logic [D_W-1:0] DIST_MAX_E8 = 33'd6000000000;
  // largest distance in 1/256 inch
  localparam int DIST_MAX_Q = 15360;

  // distance * 256 / 1e8 is floor(d / 390625), done as a reciprocal multiply
  localparam int          SCALE_SHIFT = 52;
  localparam logic [63:0] SCALE_DIV   = 64'd390625;
  localparam int          RECIP_W     = 34;
  localparam int          RECIP_LO_W  = 17;
  localparam logic [RECIP_W-1:0] SCALE_RECIP =
    RECIP_W'(((64'd1 << SCALE_SHIFT) + SCALE_DIV - 64'd1) / SCALE_DIV);

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [A_W-1:0]   a_e5;
    logic [B_W-1:0]   b;
  } irl_seg_t;

  // pipeline control from the top level
  typedef struct packed {
    logic              accept;
    logic              commit;
    logic [STAGES:1]   load;
  } irl_ctrl_t;

  localparam int SHORT_SEGS = 18;
  localparam int LONG_SEGS  = 10;

  // short-range curve, top segment first; the last entry catches everything below
  localparam irl_seg_t SHORT_CURVE [SHORT_SEGS] = '{
    '{19'd304000, 34'd120000000,  17'd0},
    '{19'd300000, 34'd1614000000, 17'd4921},
    '{19'd273000, 34'd356500000,  17'd729},
    '{19'd234000, 34'd419700000,  17'd960},
    '{19'd201000, 34'd476000000,  17'd1193},
    '{19'd178000, 34'd580300000,  17'd1710},
    '{19'd157000, 34'd609300000,  17'd1875},
    '{19'd140000, 34'd678500000,  17'd2316},
    '{19'd127000, 34'd778300000,  17'd3028},
    '{19'd106000, 34'd869900000,  17'd3750},
    '{19'd93000,  34'd1114500000, 17'd6057},
    '{19'd81000,  34'd1161400000, 17'd6560},
    '{19'd74000,  34'd1541000000, 17'd11250},
    '{19'd65000,  34'd1355900000, 17'd8749},
    '{19'd53000,  34'd1853700000, 17'd16404},
    '{19'd42000,  34'd1932700000, 17'd17895},
    '{19'd38000,  34'd3248000000, 17'd49213},
    '{19'd0,      34'd2446600000, 17'd28121}
  };

  // long-range curve, top segment first
  localparam irl_seg_t LONG_CURVE [LONG_SEGS] = '{
    '{19'd275000, 34'd0,          17'd0},
    '{19'd251000, 34'd2846100000, 17'd8202},
    '{19'd200000, 34'd2725000000, 17'd7720},
    '{19'd150000, 34'd2755900000, 17'd7874},
    '{19'd125000, 34'd3937000000, 17'd15748},
    '{19'd105000, 34'd4429100000, 17'd19685},
    '{19'd90000,  34'd5118100000, 17'd26247},
    '{19'd70000,  34'd6299200000, 17'd39370},
    '{19'd46000,  34'd9055100000, 17'd78740},
    '{19'd0,      34'd6000000000, 17'd0}
  };

endpackage

>>> hw/rtl/irl_window.sv
// per-channel sample rings and running window sums (pipeline stages 1 and 2)
module irl_window #(
  parameter int WINDOW      = irl_pkg::DEF_WINDOW,
  parameter int CHANNELS    = irl_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = irl_pkg::DEF_SAMPLE_BITS,
  localparam int SUM_W      = $clog2(WINDOW * (2 ** SAMPLE_BITS))
) (
  input  logic                                clk,
  input  logic                                rst,
  input  irl_pkg::irl_ctrl_t                  ctrl,
  input  logic [irl_pkg::CHAN_W-1:0]          channel,
  input  logic [irl_pkg::SAMPLE_W-1:0]        sample,
  input  logic [irl_pkg::MASK_W-1:0]          long_curve_mask,
  output logic [SUM_W-1:0]                    win_sum,
  output logic [irl_pkg::SAMPLE_W-1:0]        win_raw,
  output logic                                win_inrange,
  output logic                                win_use_long
);
  import irl_pkg::*;

  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ring memory with one valid bit per entry so reset reads as zero
  logic [SAMPLE_BITS-1:0] ring [DEPTH];
  logic [DEPTH-1:0]       ring_vld;

  logic [SLOT_W-1:0] write_slot [CHANNELS];
  logic [SUM_W-1:0]  window_sum [CHANNELS];

  logic [CH_IW-1:0]       ch_idx;
  logic                   inrange;
  logic [SLOT_W-1:0]      slot_cur;
  logic [SLOT_W-1:0]      slot_next;
  logic [ADDR_W-1:0]      addr;
  logic [SAMPLE_BITS-1:0] s_st;
  logic                   wr_en;

  // stage 1 registers
  logic [CH_IW-1:0]        s1_ch;
  logic [SAMPLE_BITS-1:0]  s1_s;
  logic [SAMPLE_BITS-1:0]  s1_old;
  logic                    s1_old_vld;
  logic                    s1_inrange;
  logic                    s1_use_long;
  logic [SAMPLE_W-1:0]     s1_raw;

  logic [SAMPLE_BITS-1:0]  old_eff;
  logic [SUM_W-1:0]        new_sum;

  // address of the slot this beat overwrites
  always_comb begin
    ch_idx    = CH_IW'(channel);
    inrange   = int'(channel) < CHANNELS;
    s_st      = SAMPLE_BITS'(sample);
    slot_cur  = inrange ? write_slot[ch_idx] : '0;
    slot_next = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(slot_cur + 1'b1);
    addr      = inrange ?
                ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(slot_cur)) : '0;
    wr_en     = ctrl.accept && inrange;
  end

  // ring read (old value) and write of the new sample
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s1_old <= ring[addr];
    end
    if (wr_en) begin
      ring[addr] <= s_st;
    end
  end

  // valid bits and write slots
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        write_slot[c] <= '0;
      end
    end else if (wr_en) begin
      ring_vld[addr]     <= 1'b1;
      write_slot[ch_idx] <= slot_next;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s1_ch       <= ch_idx;
      s1_s        <= s_st;
      s1_old_vld  <= ring_vld[addr];
      s1_inrange  <= inrange;
      s1_use_long <= long_curve_mask[channel];
      s1_raw      <= SAMPLE_W'(s_st);
    end
  end

  // running sum update: drop the old sample, add the new one
  always_comb begin
    old_eff = s1_old_vld ? s1_old : '0;
    new_sum = SUM_W'(window_sum[s1_ch] - SUM_W'(old_eff) + SUM_W'(s1_s));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        window_sum[c] <= '0;
      end
    end else if (ctrl.commit && s1_inrange) begin
      window_sum[s1_ch] <= new_sum;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      win_sum      <= new_sum;
      win_raw      <= s1_raw;
      win_inrange  <= s1_inrange;
      win_use_long <= s1_use_long;
    end
  end

  // the slot in use is always inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> int'(slot_cur) < WINDOW)
    else $error("write slot beyond window");

  // a committed sum never exceeds a full window of maximum samples
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.commit && s1_inrange) |-> int'(new_sum) <= WINDOW * ((2 ** SAMPLE_BITS) - 1))
    else $error("window sum out of range");

endmodule

>>> hw/rtl/irl_linearize.sv
// window average and piecewise-linear distance mapping (pipeline stages 3 to 9)
module irl_linearize #(
  parameter int WINDOW      = irl_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = irl_pkg::DEF_SAMPLE_BITS,
  localparam int SUM_W      = $clog2(WINDOW * (2 ** SAMPLE_BITS))
) (
  input  logic                          clk,
  input  irl_pkg::irl_ctrl_t            ctrl,
  input  logic [SUM_W-1:0]              win_sum,
  input  logic [irl_pkg::SAMPLE_W-1:0]  win_raw,
  input  logic                          win_inrange,
  input  logic                          win_use_long,
  output logic [irl_pkg::SAMPLE_W-1:0]  raw_echo,
  output logic [irl_pkg::DIST_W-1:0]    distance
);
  import irl_pkg::*;

  // exact divide by WINDOW: multiply by a rounded-up reciprocal and shift
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int AVG_PW  = 2 * SUM_W + 1;
  localparam int PW      = SAMPLE_BITS + 9;
  localparam int PROD_W  = B_W + PW;
  localparam int PP_W    = D_W + RECIP_LO_W;
  localparam int FULL_W  = D_W + RECIP_W;

  // carried fields
  logic [SAMPLE_W-1:0] raw_d [3:STAGES];
  logic                inr_d [3:STAGES-1];
  logic                long_d [3:4];

  logic [AVG_PW-1:0]      avg_prod;
  logic [SAMPLE_BITS-1:0] s3_avg;
  logic [PW-1:0]          s4_p;
  logic [PW-1:0]          p_used;
  irl_seg_t               short_seg;
  irl_seg_t               long_seg;
  irl_seg_t               seg;
  logic [A_W-1:0]         s5_a;
  logic [B_W-1:0]         s5_b;
  logic [PW-1:0]          s5_p;
  logic [A_W-1:0]         s6_a;
  logic [PROD_W-1:0]      s6_prod;
  logic [A_W-1:0]         diff;
  logic [D_W-1:0]         d_clamp;
  logic [D_W-1:0]         s7_d;
  logic [PP_W-1:0]        s8_pp_lo;
  logic [PP_W-1:0]        s8_pp_hi;
  logic [FULL_W-1:0]      full;

  // side fields follow their beat down the pipe
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      raw_d[3]  <= win_raw;
      inr_d[3]  <= win_inrange;
      long_d[3] <= win_use_long;
    end
    if (ctrl.load[4]) begin
      long_d[4] <= long_d[3];
    end
    for (int k = 4; k <= STAGES; k++) begin
      if (ctrl.load[k]) begin
        raw_d[k] <= raw_d[k-1];
      end
    end
    for (int k = 4; k <= STAGES - 1; k++) begin
      if (ctrl.load[k]) begin
        inr_d[k] <= inr_d[k-1];
      end
    end
  end

  // stage 3: window average
  assign avg_prod = AVG_PW'(win_sum) * AVG_PW'(RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s3_avg <= SAMPLE_BITS'(avg_prod >> DIV_SHIFT);
    end
  end

  // stage 4: voltage in 1e-5 V
  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s4_p <= PW'(PW'(s3_avg) * PW'(VOLT_SCALE));
    end
  end

  // stage 5: segment search, short curve voltage held at its floor
  always_comb begin
    p_used = (!long_d[4] && (s4_p <= PW'(SHORT_FLOOR_P))) ? PW'(SHORT_FLOOR_P) : s4_p;
    short_seg = SHORT_CURVE[SHORT_SEGS-1];
    for (int i = SHORT_SEGS - 2; i >= 0; i--) begin
      if (32'(p_used) > 32'(SHORT_CURVE[i].thr)) begin
        short_seg = SHORT_CURVE[i];
      end
    end
    long_seg = LONG_CURVE[LONG_SEGS-1];
    for (int i = LONG_SEGS - 2; i >= 0; i--) begin
      if (32'(p_used) > 32'(LONG_CURVE[i].thr)) begin
        long_seg = LONG_CURVE[i];
      end
    end
    seg = long_d[4] ? long_seg : short_seg;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s5_a <= seg.a_e5;
      s5_b <= seg.b;
      s5_p <= p_used;
    end
  end

  // stage 6: slope times voltage
  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      s6_a    <= s5_a;
      s6_prod <= PROD_W'(s5_b) * PROD_W'(s5_p);
    end
  end

  // stage 7: offset minus slope term, clamped to 0 .. 60 inch
  always_comb begin
    diff = '0;
    if (64'(s6_prod) <= 64'(s6_a)) begin
      diff = A_W'(s6_a - A_W'(s6_prod));
    end
    d_clamp = (diff > A_W'(DIST_MAX_E8)) ? DIST_MAX_E8 : D_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      s7_d <= d_clamp;
    end
  end

  // stage 8: scale to 1/256 inch, reciprocal split into two partial products
  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      s8_pp_lo <= PP_W'(s7_d) * PP_W'(SCALE_RECIP[RECIP_LO_W-1:0]);
      s8_pp_hi <= PP_W'(s7_d) * PP_W'(SCALE_RECIP[RECIP_W-1:RECIP_LO_W]);
    end
  end

  // stage 9: combine partial products into the result register
  assign full = (FULL_W'(s8_pp_hi) << RECIP_LO_W) + FULL_W'(s8_pp_lo);

  always_ff @(posedge clk) begin
    if (ctrl.load[9]) begin
      distance <= inr_d[STAGES-1] ? DIST_W'(full >> SCALE_SHIFT) : '0;
    end
  end

  assign raw_echo = raw_d[STAGES];

endmodule

>>> hw/rtl/ir_range_average_linearize_core.sv
// ir range sensor averager and linearizer, top level with stream ports
// an accepted input beat reaches its result beat through the registered pipeline stages
// throughput: one beat per cycle; stages hold and close up bubbles when the output stalls
// the ring read, running-sum update and segment multiply each sit in their own stage
// reset: clears pipeline valids, rings (through per-entry valid bits), sums and slots
// reset: the long-curve mask comes up as 4'b1000; no clearing pass is needed
module ir_range_average_linearize_core #(
  parameter int WINDOW      = irl_pkg::DEF_WINDOW,
  parameter int CHANNELS    = irl_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = irl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [irl_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // sample[9:0], zero pad
  input  logic [irl_pkg::CHAN_W-1:0]        s_axis_tuser,   // channel[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [irl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // raw_echo[9:0], distance[23:10]
  input  logic                              cfg_wr_en,
  input  logic [irl_pkg::MASK_W-1:0]        cfg_wr_data     // long_curve_mask
);
  import irl_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * (2 ** SAMPLE_BITS));

  logic [MASK_W-1:0]   long_curve_mask;
  logic [STAGES:1]     vld;
  logic [STAGES+1:1]   adv;
  irl_ctrl_t           ctrl;

  logic [SUM_W-1:0]    win_sum;
  logic [SAMPLE_W-1:0] win_raw;
  logic                win_inrange;
  logic                win_use_long;
  logic [SAMPLE_W-1:0] raw_echo;
  logic [DIST_W-1:0]   distance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_curve_mask <= MASK_RESET;
    end else if (cfg_wr_en) begin
      long_curve_mask <= cfg_wr_data;
    end
  end

  // a stage may load when it is empty or its beat moves on
  always_comb begin
    adv[STAGES+1] = m_axis_tready;
    for (int k = STAGES; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    ctrl.accept = s_axis_tvalid && adv[1];
    ctrl.commit = vld[1] && adv[2];
    ctrl.load   = adv[STAGES:1];
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  irl_window #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .channel         (s_axis_tuser),
    .sample          (s_axis_tdata[SAMPLE_W-1:0]),
    .long_curve_mask (long_curve_mask),
    .win_sum         (win_sum),
    .win_raw         (win_raw),
    .win_inrange     (win_inrange),
    .win_use_long    (win_use_long)
  );

  irl_linearize #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_linearize (
    .clk          (clk),
    .ctrl         (ctrl),
    .win_sum      (win_sum),
    .win_raw      (win_raw),
    .win_inrange  (win_inrange),
    .win_use_long (win_use_long),
    .raw_echo     (raw_echo),
    .distance     (distance)
  );

  // stream outputs
  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[STAGES];
  assign m_axis_tdata  = {distance, raw_echo};

  // an accepted beat always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[1])
    else $error("accepted beat lost at stage 1");

  // an empty pipe never refuses input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> s_axis_tready)
    else $error("empty pipeline not ready");

  // distances stay within 60 inch
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> int'(m_axis_tdata[OUT_DATA_W-1:SAMPLE_W]) <= DIST_MAX_Q)
    else $error("distance above 60 inch");

endmodule

>>> verif/testbench.sv
// stream testbench for the ir range averager and linearizer core
`timescale 1ns / 100ps

module testbench;

  // window and sensor curve constants, voltage in 1e-5 V, offsets in 1e-3 inch
  localparam int     WIN_LEN       = 20;
  localparam int     CHAN_COUNT    = 4;
  localparam longint VOLT_PER_LSB  = 489;
  localparam longint SHORT_FLOOR_V = 31000;
  localparam longint FAR_LIMIT_E8  = 64'd6000000000;
  localparam int     LATENCY       = irl_pkg::STAGES;
  localparam int     STALL_LIMIT   = 4000;
  localparam int     PHASE_ITEMS   = 170;
  localparam int     DIRECTED_ROWS = 25;

  localparam longint SR_KNEE [18] = '{304000, 300000, 273000, 234000, 201000, 178000,
    157000, 140000, 127000, 106000, 93000, 81000, 74000, 65000, 53000, 42000, 38000, -1};
  localparam longint SR_OFS [18] = '{1200, 16140, 3565, 4197, 4760, 5803, 6093, 6785,
    7783, 8699, 11145, 11614, 15410, 13559, 18537, 19327, 32480, 24466};
  localparam longint SR_SLOPE [18] = '{0, 4921, 729, 960, 1193, 1710, 1875, 2316, 3028,
    3750, 6057, 6560, 11250, 8749, 16404, 17895, 49213, 28121};
  localparam longint LR_KNEE [10] = '{275000, 251000, 200000, 150000, 125000, 105000,
    90000, 70000, 46000, -1};
  localparam longint LR_OFS [10] = '{0, 28461, 27250, 27559, 39370, 44291, 51181, 62992,
    90551, 60000};
  localparam longint LR_SLOPE [10] = '{0, 8202, 7720, 7874, 15748, 19685, 26247, 39370,
    78740, 0};

  typedef struct packed {
    logic [9:0]  raw;
    logic [13:0] dist_q;
  } reading_t;

  // directed probe: channel, sample, and a distance typed in when fixed is set
  typedef struct packed {
    logic [1:0]  ch;
    logic [9:0]  smp;
    logic        fixed;
    logic [13:0] dist_q;
  } probe_t;

  localparam probe_t PROBES [DIRECTED_ROWS] = '{
    '{2'd3, 10'd0,    1'b1, 14'd15360},  // long curve at zero volts reads 60 in
    '{2'd0, 10'd0,    1'b0, 14'd0},      // short curve voltage held at its floor
    '{2'd1, 10'd1023, 1'b0, 14'd0},
    '{2'd2, 10'd341,  1'b0, 14'd0},
    '{2'd2, 10'd682,  1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b1, 14'd15360},  // one full-scale sample still averages low
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b0, 14'd0},
    '{2'd3, 10'd1023, 1'b1, 14'd0}       // ring full of full scale, long curve reads 0
  };

  localparam logic [3:0] MASK_PLAN [4] = '{4'h0, 4'hF, 4'h5, 4'hA};

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [irl_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;   // sample[9:0], zero pad
  logic [irl_pkg::CHAN_W-1:0]       s_axis_tuser = '0;   // channel[1:0]
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [irl_pkg::OUT_DATA_W-1:0]   m_axis_tdata;        // raw_echo[9:0], distance[23:10]
  logic                             cfg_wr_en = 1'b0;
  logic [irl_pkg::MASK_W-1:0]       cfg_wr_data = '0;    // long_curve_mask

  // predictor state
  logic [3:0]  curve_mask = irl_pkg::MASK_RESET;
  logic [9:0]  window_ring [CHAN_COUNT][WIN_LEN];
  int unsigned ring_slot [CHAN_COUNT];
  int unsigned ring_total [CHAN_COUNT];

  reading_t    pending_readings [$];
  reading_t    oldest;
  bit          steady = 1'b0;
  int          fail_count = 0;
  int          beats_sent = 0;
  int          readings_seen = 0;
  int          masks_used = 1;
  int          quiet_cycles = 0;

  ir_range_average_linearize_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // window average to distance in 1/256 inch through the selected curve
  function automatic logic [13:0] curve_distance(input logic long_sel, input int unsigned avg);
    longint volt;
    longint dd;
    int     k;
    volt = longint'(avg) * VOLT_PER_LSB;
    k = 0;
    if (long_sel) begin
      while (k < 9 && volt <= LR_KNEE[k]) k++;
      dd = LR_OFS[k] * 100000 - LR_SLOPE[k] * volt;
    end else begin
      if (volt <= SHORT_FLOOR_V) volt = SHORT_FLOOR_V;
      while (k < 17 && volt <= SR_KNEE[k]) k++;
      dd = SR_OFS[k] * 100000 - SR_SLOPE[k] * volt;
    end
    if (dd < 0) dd = 0;
    if (dd > FAR_LIMIT_E8) dd = FAR_LIMIT_E8;
    return 14'((dd * 256) / 100000000);
  endfunction

  // store the sample in its ring, update the running sum, return the distance
  function automatic logic [13:0] absorb_sample(input logic [1:0] ch, input logic [9:0] smp);
    int unsigned pos;
    pos = ring_slot[ch];
    ring_total[ch] = ring_total[ch] - window_ring[ch][pos] + smp;
    window_ring[ch][pos] = smp;
    ring_slot[ch] = (pos == WIN_LEN - 1) ? 0 : pos + 1;
    return curve_distance(curve_mask[ch], ring_total[ch] / WIN_LEN);
  endfunction

  task automatic note_failure(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  // one input beat, entered and left at a falling edge
  task automatic send_beat(input logic [1:0] ch, input logic [9:0] smp, input logic fixed,
                           input logic [13:0] fixed_dist);
    reading_t    r;
    logic [13:0] d;
    while (!steady && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, smp};
    s_axis_tuser  <= ch;
    do @(posedge clk); while (!s_axis_tready);
    d = absorb_sample(ch, smp);
    r.raw    = smp;
    r.dist_q = fixed ? fixed_dist : d;
    pending_readings.push_back(r);
    beats_sent++;
    @(negedge clk);
  endtask

  // let the pipe drain, then write the mask
  task automatic write_mask(input logic [3:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    curve_mask = value;
    masks_used++;
  endtask

  // sink side ready, random stalls except in the steady stretch
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 10);
  end

  // result check against the oldest pending reading
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        note_failure("unexpected result beat, raw_echo", -1, m_axis_tdata[9:0]);
      end else begin
        oldest = pending_readings.pop_front();
        if (m_axis_tdata[9:0] !== oldest.raw)
          note_failure("raw_echo", oldest.raw, m_axis_tdata[9:0]);
        if (m_axis_tdata[23:10] !== oldest.dist_q)
          note_failure("distance", oldest.dist_q, m_axis_tdata[23:10]);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_readings.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // stimulus
  initial begin
    int          sent;
    int          lvl;
    int          jit;
    int          len;
    int          v;
    logic [1:0]  ch;
    logic [3:0]  next_mask;
    for (int c = 0; c < CHAN_COUNT; c++) begin
      ring_slot[c]  = 0;
      ring_total[c] = 0;
      for (int k = 0; k < WIN_LEN; k++) window_ring[c][k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed probes under the reset mask
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_beat(PROBES[i].ch, PROBES[i].smp, PROBES[i].fixed, PROBES[i].dist_q);

    // random phases, one mask setting each
    for (int ph = 0; ph < 5; ph++) begin
      next_mask = (ph < 4) ? MASK_PLAN[ph] : 4'($urandom_range(15));
      write_mask(next_mask);
      steady = (ph == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        ch = 2'($urandom_range(3));
        if ($urandom_range(99) < 70) begin
          // run on one channel around a level, sweeps the window average
          lvl = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(700);
          jit = $urandom_range(64);
          len = $urandom_range(40, 20);
          for (int k = 0; k < len; k++) begin
            v = lvl + int'($urandom_range(2 * jit)) - jit;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_beat(ch, 10'(v), 1'b0, '0);
          end
          sent += len;
        end else begin
          // scattered noise across channels
          len = $urandom_range(8, 1);
          for (int k = 0; k < len; k++)
            send_beat(2'($urandom_range(3)), 10'($urandom_range(1023)), 1'b0, '0);
          sent += len;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("sent %0d sample beats on %0d curve-mask settings, checked %0d results",
             beats_sent, masks_used, readings_seen);
    $display("channel runs swept window averages over both curves, %0d mismatches",
             fail_count);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
